FILE: design/huffman_code_builder_core_assert.svh
// ----------------------------------------------------------------------------
// huffman code builder assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BUILDER_CORE_ASSERT_SVH
`define HUFFMAN_CODE_BUILDER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define HCB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define HCB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/hcb_pkg.sv
// ----------------------------------------------------------------------------
// hcb_pkg
// shared widths and controller/datapath command and status types
// ----------------------------------------------------------------------------
`default_nettype none

package hcb_pkg;

   // fixed payload widths
   localparam int IN_WEIGHT_W = 24;
   localparam int INDEX_W     = 6;
   localparam int LENGTH_W    = 6;
   localparam int CODE_W      = 63;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic build_init;
      logic scan_init;
      logic scan_run;
      logic merge_left;
      logic merge_right;
      logic walk_init;
      logic walk_issue;
      logic walk_step;
      logic emit;
      logic walk_next;
      logic finish;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic merges_done;
      logic scan_done;
      logic has_parent;
      logic out_free;
      logic last_sym;
   } status_type;

endpackage

`default_nettype wire

FILE: design/hcb_if.sv
// ----------------------------------------------------------------------------
// hcb channel interfaces
// valid/ready channels for weight loads and code results
// ----------------------------------------------------------------------------
`default_nettype none

// weight load channel
interface hcb_req_if;
   logic                              valid;
   logic                              ready;
   logic [hcb_pkg::IN_WEIGHT_W-1:0]   symbol_weight;
   logic                              last_symbol;

   modport source (output valid, output symbol_weight, output last_symbol, input ready);
   modport sink   (input valid, input symbol_weight, input last_symbol, output ready);
endinterface

// code result channel
interface hcb_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [hcb_pkg::INDEX_W-1:0]    symbol_index;
   logic [hcb_pkg::LENGTH_W-1:0]   code_length;
   logic [hcb_pkg::CODE_W-1:0]     code_value;
   logic                           final_code;

   modport source (output valid, output symbol_index, output code_length,
                   output code_value, output final_code, input ready);
   modport sink   (input valid, input symbol_index, input code_length,
                   input code_value, input final_code, output ready);
endinterface

`default_nettype wire

FILE: design/hcb_ram.sv
// ----------------------------------------------------------------------------
// hcb_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/hcb_ctrl.sv
// ----------------------------------------------------------------------------
// hcb_ctrl
// sequencer for load, tree build (scan and merge) and code walk
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_last,
   output logic                     req_ready,
   input  wire hcb_pkg::status_type status,
   output hcb_pkg::cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_CLEAR,
      ST_CHECK,
      ST_SCAN,
      ST_MERGE_L,
      ST_MERGE_R,
      ST_WALK_CHECK,
      ST_WALK_STEP,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   // next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      ready_in = ready_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid && ready_ff) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  ready_in = 1'b0;
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_CLEAR: begin
            cmd.build_init = 1'b1;
            state_in       = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.merges_done) begin
               cmd.walk_init = 1'b1;
               state_in      = ST_WALK_CHECK;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (status.scan_done) begin
               state_in = ST_MERGE_L;
            end
         end
         ST_MERGE_L: begin
            cmd.merge_left = 1'b1;
            state_in       = ST_MERGE_R;
         end
         ST_MERGE_R: begin
            cmd.merge_right = 1'b1;
            state_in        = ST_CHECK;
         end
         ST_WALK_CHECK: begin
            if (status.has_parent) begin
               cmd.walk_issue = 1'b1;
               state_in       = ST_WALK_STEP;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_WALK_STEP: begin
            cmd.walk_step = 1'b1;
            state_in      = ST_WALK_CHECK;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.last_sym) begin
                  cmd.finish = 1'b1;
                  ready_in   = 1'b1;
                  state_in   = ST_LOAD;
               end else begin
                  cmd.walk_next = 1'b1;
                  state_in      = ST_WALK_CHECK;
               end
            end
         end
         default: begin
            ready_in = 1'b1;
            state_in = ST_LOAD;
         end
      endcase
   end

   // state and registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

endmodule

`default_nettype wire

FILE: design/hcb_datapath.sv
// ----------------------------------------------------------------------------
// hcb_datapath
// node memories, least-weight scan, merge writes, code walk, output register
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_datapath #(
   parameter int MAX_SYMBOLS = 64,
   parameter int WEIGHT_BITS = 24
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire hcb_pkg::cmd_type                   cmd,
   output hcb_pkg::status_type                     status,
   input  wire logic [hcb_pkg::IN_WEIGHT_W-1:0]    req_weight,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_valid,
   output logic      [hcb_pkg::INDEX_W-1:0]        rsp_symbol_index,
   output logic      [hcb_pkg::LENGTH_W-1:0]       rsp_code_length,
   output logic      [hcb_pkg::CODE_W-1:0]         rsp_code_value,
   output logic                                    rsp_final_code
);

   localparam int NODES  = 2 * MAX_SYMBOLS;
   localparam int NODE_W = $clog2(NODES);
   localparam int KW     = NODE_W + 1;
   localparam int CNT_W  = $clog2(MAX_SYMBOLS + 1);
   localparam int LOAD_W = (WEIGHT_BITS < hcb_pkg::IN_WEIGHT_W) ? WEIGHT_BITS
                                                               : hcb_pkg::IN_WEIGHT_W;
   localparam int NW     = LOAD_W + $clog2(MAX_SYMBOLS);
   localparam int LINK_W = NODE_W + 1;

   // control registers
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [KW-1:0]     k_ff, k_in;
   logic [KW-1:0]     i_ff, i_in;
   logic              rd_valid_ff, rd_valid_in;
   logic              have1_ff, have1_in;
   logic              have2_ff, have2_in;
   logic [NODES-1:0]  has_parent_ff, has_parent_in;
   logic [CNT_W-1:0]  sym_ff, sym_in;
   logic              out_valid_ff, out_valid_in;

   // payload registers
   logic [NODE_W-1:0]            rd_idx_ff, rd_idx_in;
   logic [NW-1:0]                m1_ff, m1_in;
   logic [NW-1:0]                m2_ff, m2_in;
   logic [NODE_W-1:0]            s1_ff, s1_in;
   logic [NODE_W-1:0]            s2_ff, s2_in;
   logic [NODE_W-1:0]            c_ff, c_in;
   logic [hcb_pkg::LENGTH_W-1:0] len_ff, len_in;
   logic [hcb_pkg::CODE_W-1:0]   code_ff, code_in;
   logic [hcb_pkg::INDEX_W-1:0]  out_index_ff, out_index_in;
   logic [hcb_pkg::LENGTH_W-1:0] out_length_ff, out_length_in;
   logic [hcb_pkg::CODE_W-1:0]   out_code_ff, out_code_in;
   logic                         out_final_ff, out_final_in;

   // memory ports
   logic              w_wr_en, w_rd_en;
   logic [NODE_W-1:0] w_wr_addr;
   logic [NW-1:0]     w_wr_data, w_rd_data;
   logic              link_wr_en, link_rd_en;
   logic [NODE_W-1:0] link_wr_addr;
   logic [LINK_W-1:0] link_wr_data, link_rd_data;

   logic [KW-1:0]     two_n;
   logic              scan_issue;
   logic              last_sym;

   assign two_n      = KW'(count_ff) << 1;
   assign scan_issue = i_ff < k_ff;
   assign last_sym   = sym_ff == count_ff;

   // node weights: leaves at load, internal nodes at merge
   hcb_ram #(.WIDTH(NW), .DEPTH(NODES)) u_weight_ram (
      .clock   (clock),
      .wr_en   (w_wr_en),
      .wr_addr (w_wr_addr),
      .wr_data (w_wr_data),
      .rd_en   (w_rd_en),
      .rd_addr (i_ff[NODE_W-1:0]),
      .rd_data (w_rd_data)
   );

   // parent link with right-child flag in bit 0
   hcb_ram #(.WIDTH(LINK_W), .DEPTH(NODES)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (link_rd_en),
      .rd_addr (c_ff),
      .rd_data (link_rd_data)
   );

   // datapath next values
   always_comb begin
      count_in      = count_ff;
      k_in          = k_ff;
      i_in          = i_ff;
      rd_valid_in   = rd_valid_ff;
      rd_idx_in     = rd_idx_ff;
      have1_in      = have1_ff;
      have2_in      = have2_ff;
      m1_in         = m1_ff;
      m2_in         = m2_ff;
      s1_in         = s1_ff;
      s2_in         = s2_ff;
      has_parent_in = has_parent_ff;
      sym_in        = sym_ff;
      c_in          = c_ff;
      len_in        = len_ff;
      code_in       = code_ff;
      out_valid_in  = out_valid_ff;
      out_index_in  = out_index_ff;
      out_length_in = out_length_ff;
      out_code_in   = out_code_ff;
      out_final_in  = out_final_ff;
      w_wr_en       = 1'b0;
      w_wr_addr     = NODE_W'(count_ff) + NODE_W'(1);
      w_wr_data     = NW'(req_weight[LOAD_W-1:0]);
      w_rd_en       = 1'b0;
      link_wr_en    = 1'b0;
      link_wr_addr  = s1_ff;
      link_wr_data  = {k_ff[NODE_W-1:0], 1'b0};
      link_rd_en    = 1'b0;

      // leaf load, dropped once the table is full
      if (cmd.load && (count_ff < CNT_W'(MAX_SYMBOLS))) begin
         w_wr_en  = 1'b1;
         count_in = count_ff + CNT_W'(1);
      end

      // start of build: no node has a parent yet
      if (cmd.build_init) begin
         has_parent_in = '0;
         k_in          = KW'(count_ff) + KW'(1);
      end

      if (cmd.scan_init) begin
         i_in        = KW'(1);
         have1_in    = 1'b0;
         have2_in    = 1'b0;
         rd_valid_in = 1'b0;
      end

      // scan nodes 1..k-1, keep the two smallest free ones, lower index wins ties
      if (cmd.scan_run) begin
         rd_valid_in = scan_issue;
         rd_idx_in   = i_ff[NODE_W-1:0];
         if (scan_issue) begin
            w_rd_en = 1'b1;
            i_in    = i_ff + KW'(1);
         end
         if (rd_valid_ff && !has_parent_ff[rd_idx_ff]) begin
            if (!have1_ff || (w_rd_data < m1_ff)) begin
               s2_in    = s1_ff;
               m2_in    = m1_ff;
               have2_in = have1_ff;
               s1_in    = rd_idx_ff;
               m1_in    = w_rd_data;
               have1_in = 1'b1;
            end else if (!have2_ff || (w_rd_data < m2_ff)) begin
               s2_in    = rd_idx_ff;
               m2_in    = w_rd_data;
               have2_in = 1'b1;
            end
         end
      end

      // new node k: weight, left child link, both children taken
      if (cmd.merge_left) begin
         w_wr_en           = 1'b1;
         w_wr_addr         = k_ff[NODE_W-1:0];
         w_wr_data         = m1_ff + m2_ff;
         link_wr_en        = 1'b1;
         has_parent_in[s1_ff] = 1'b1;
         has_parent_in[s2_ff] = 1'b1;
      end

      // right child link
      if (cmd.merge_right) begin
         link_wr_en   = 1'b1;
         link_wr_addr = s2_ff;
         link_wr_data = {k_ff[NODE_W-1:0], 1'b1};
         k_in         = k_ff + KW'(1);
      end

      // code walk from leaf toward the root
      if (cmd.walk_init) begin
         sym_in  = CNT_W'(1);
         c_in    = NODE_W'(1);
         len_in  = '0;
         code_in = '0;
      end
      if (cmd.walk_issue) begin
         link_rd_en = 1'b1;
      end
      if (cmd.walk_step) begin
         code_in = code_ff | (hcb_pkg::CODE_W'(link_rd_data[0]) << len_ff);
         len_in  = len_ff + hcb_pkg::LENGTH_W'(1);
         c_in    = link_rd_data[LINK_W-1:1];
      end
      if (cmd.walk_next) begin
         sym_in  = sym_ff + CNT_W'(1);
         c_in    = NODE_W'(sym_ff) + NODE_W'(1);
         len_in  = '0;
         code_in = '0;
      end
      if (cmd.finish) begin
         count_in = '0;
      end

      // output register
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         out_valid_in  = 1'b1;
         out_index_in  = hcb_pkg::INDEX_W'(sym_ff - CNT_W'(1));
         out_length_in = len_ff;
         out_code_in   = code_ff;
         out_final_in  = last_sym;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         k_ff          <= '0;
         i_ff          <= '0;
         rd_valid_ff   <= 1'b0;
         have1_ff      <= 1'b0;
         have2_ff      <= 1'b0;
         has_parent_ff <= '0;
         sym_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         k_ff          <= k_in;
         i_ff          <= i_in;
         rd_valid_ff   <= rd_valid_in;
         have1_ff      <= have1_in;
         have2_ff      <= have2_in;
         has_parent_ff <= has_parent_in;
         sym_ff        <= sym_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      m1_ff         <= m1_in;
      m2_ff         <= m2_in;
      s1_ff         <= s1_in;
      s2_ff         <= s2_in;
      c_ff          <= c_in;
      len_ff        <= len_in;
      code_ff       <= code_in;
      out_index_ff  <= out_index_in;
      out_length_ff <= out_length_in;
      out_code_ff   <= out_code_in;
      out_final_ff  <= out_final_in;
   end

   // status to the controller
   always_comb begin
      status.merges_done = k_ff >= two_n;
      status.scan_done   = !scan_issue && !rd_valid_ff;
      status.has_parent  = has_parent_ff[c_ff];
      status.out_free    = !out_valid_ff || rsp_ready;
      status.last_sym    = last_sym;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_symbol_index = out_index_ff;
   assign rsp_code_length  = out_length_ff;
   assign rsp_code_value   = out_code_ff;
   assign rsp_final_code   = out_final_ff;

endmodule

`default_nettype wire

FILE: design/huffman_code_builder_core.sv
// ----------------------------------------------------------------------------
// huffman_code_builder_core
// builds a huffman tree from loaded weights and streams one code per symbol
// ----------------------------------------------------------------------------
// usage:
//   req_chan carries one symbol weight per transfer, one transfer per cycle
//   while loading; weights past MAX_SYMBOLS are dropped. the transfer with
//   last_symbol set closes the table and starts the build.
//   rsp_chan then carries one code per loaded symbol in load order; the
//   last one has final_code set. req_chan ready stays low from the closing
//   transfer until the final code has entered the output register.
// build and walk, n symbols:
//   build: each merge k = n+1..2n-1 scans nodes 1..k-1 for the two lightest free
//   nodes through the single read port of the weight memory.
//   walk: one parent-link memory read per tree level of each code.
// reset clears the load count and control state and leaves the block ready.
// a stalled rsp_chan holds the current code in the output register and the
// walk waits; loading resumes as soon as the final code is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_builder_core #(
   parameter int MAX_SYMBOLS = 64,
   parameter int WEIGHT_BITS = 24
) (
   input wire logic   clock,
   input wire logic   reset,
   hcb_req_if.sink    req_chan,
   hcb_rsp_if.source  rsp_chan
);

   hcb_pkg::cmd_type    cmd;
   hcb_pkg::status_type status;
   logic                req_ready;

   // sequencer
   hcb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_symbol),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // memories and arithmetic
   hcb_datapath #(
      .MAX_SYMBOLS (MAX_SYMBOLS),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_weight       (req_chan.symbol_weight),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_symbol_index (rsp_chan.symbol_index),
      .rsp_code_length  (rsp_chan.code_length),
      .rsp_code_value   (rsp_chan.code_value),
      .rsp_final_code   (rsp_chan.final_code)
   );

   assign req_chan.ready = req_ready;

endmodule

`default_nettype wire

FILE: design/hcb_checker.sv
// ----------------------------------------------------------------------------
// hcb_checker
// port-level checks on load closing, code output and result stall
// ----------------------------------------------------------------------------
`default_nettype none

`include "huffman_code_builder_core_assert.svh"

module hcb_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_ready,
   input wire logic                             req_last,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [hcb_pkg::INDEX_W-1:0]      rsp_index,
   input wire logic [hcb_pkg::LENGTH_W-1:0]     rsp_length,
   input wire logic [hcb_pkg::CODE_W-1:0]       rsp_code,
   input wire logic                             rsp_final
);

   // closing transfer starts the build, so no load in the next cycle
   `HCB_ASSERT_NEXT(a_build_blocks_load, clock, reset, req_valid && req_ready && req_last, !req_ready, "load accepted right after table close")

   // codes other than the final one come out while loading is still blocked
   `HCB_ASSERT_NOW(a_no_load_mid_output, clock, reset, rsp_valid && !rsp_final, !req_ready, "load open before final code")

   // no code bits above the code length
   `HCB_ASSERT_NOW(a_code_fits_length, clock, reset, rsp_valid, (rsp_code >> rsp_length) == '0, "code bits beyond length")

   // stalled result holds
   `HCB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_index) && $stable(rsp_length) && $stable(rsp_code) && $stable(rsp_final), "stalled result changed")

endmodule

bind huffman_code_builder_core hcb_checker u_hcb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .req_last   (req_chan.last_symbol),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_index  (rsp_chan.symbol_index),
   .rsp_length (rsp_chan.code_length),
   .rsp_code   (rsp_chan.code_value),
   .rsp_final  (rsp_chan.final_code)
);

`default_nettype wire
